// File: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros used by the checker file.
// Each expects clk_i and rst_ni in scope.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define SOST_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Condition must never be seen at a clock edge outside reset.
`define SOST_NEVER(name, cond, msg) \
  `SOST_ASSERT(name, !(cond), msg)

`endif

// File: rtl/core/sost_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sost_pkg
// Types, constants and codes of the self-organising search table.
// ----------------------------------------------------------------------------
package sost_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int COUNT_WIDTH = 16;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int LEN_W       = IDX_W + 1;

  // field widths of the channels
  localparam int KEY_W      = 32;
  localparam int SLOT_W     = 6;
  localparam int POS_W      = 6;
  localparam int HIT_W      = 16;
  localparam int MODE_W     = 2;
  localparam int TLEN_W     = 7;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 7;

  localparam logic [TLEN_W-1:0] TLEN_RESET = TLEN_W'(64);

  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_SEARCH = 1'b1;

  typedef enum logic [MODE_W-1:0] {
    POL_PLAIN     = 2'd0,
    POL_MTF       = 2'd1,
    POL_TRANSPOSE = 2'd2,
    POL_FREQ      = 2'd3
  } policy_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_POLICY_MODE  = 1'd0,
    REG_TABLE_LENGTH = 1'd1
  } reg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SHIFT,
    ST_PLACE,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [KEY_W-1:0]       key;
    logic [COUNT_WIDTH-1:0] count;
  } entry_t;

  typedef struct packed {
    policy_e          mode;
    logic [LEN_W-1:0] len;   // slots searched, already clamped to the depth
  } cfg_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    entry_t           wdata;
    logic [IDX_W-1:0] raddr;
  } mem_req_t;

endpackage

// File: rtl/core/sost_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sost_in_if / sost_out_if
// Valid/ready channels carrying search items and results.
// ----------------------------------------------------------------------------
interface sost_in_if ();
  logic                              valid;
  logic                              ready;
  logic                              op;
  logic [sost_pkg::SLOT_W-1:0]       slot_index;
  logic signed [sost_pkg::KEY_W-1:0] key;

  modport source (output valid, op, slot_index, key, input ready);
  modport sink   (input valid, op, slot_index, key, output ready);
endinterface

interface sost_out_if ();
  logic                              valid;
  logic                              ready;
  logic                              found;
  logic signed [sost_pkg::KEY_W-1:0] match_key;
  logic [sost_pkg::POS_W-1:0]        old_position;
  logic [sost_pkg::POS_W-1:0]        new_position;
  logic [sost_pkg::HIT_W-1:0]        hit_count;

  modport source (output valid, found, match_key, old_position, new_position,
                  hit_count, input ready);
  modport sink   (input valid, found, match_key, old_position, new_position,
                  hit_count, output ready);
endinterface

// File: rtl/core/sost_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sost_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module sost_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 48
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/sost_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sost_ctrl
// Sequencer: scans the entry RAM, walks the reorder, writes back, and holds
// the result register. Written flags live here in flops.
// ----------------------------------------------------------------------------
module sost_ctrl (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  sost_pkg::cfg_t               cfg_i,
  sost_in_if.sink                      in_i,
  sost_out_if.source                   out_o,
  output sost_pkg::mem_req_t           mem_o,
  input  sost_pkg::entry_t             mem_rdata_i
);

  localparam int IDX_W = sost_pkg::IDX_W;
  localparam int LEN_W = sost_pkg::LEN_W;
  localparam int CNT_W = sost_pkg::COUNT_WIDTH;

  sost_pkg::state_e state_q, state_d;

  logic [IDX_W-1:0]                cmp_idx_q, cmp_idx_d;
  logic [IDX_W-1:0]                pos_q, pos_d;
  logic [IDX_W-1:0]                dst_q, dst_d;
  logic [LEN_W-1:0]                len_q, len_d;
  logic [sost_pkg::KEY_W-1:0]      key_q, key_d;
  logic [CNT_W-1:0]                e_count_q, e_count_d;
  logic                            found_q, found_d;
  logic [sost_pkg::TABLE_DEPTH-1:0] written_q, written_d;

  logic                            out_valid_q, out_valid_d;
  logic                            out_found_q, out_found_d;
  logic [sost_pkg::KEY_W-1:0]      out_key_q, out_key_d;
  logic [sost_pkg::POS_W-1:0]      out_old_q, out_old_d;
  logic [sost_pkg::POS_W-1:0]      out_new_q, out_new_d;
  logic [sost_pkg::HIT_W-1:0]      out_cnt_q, out_cnt_d;

  logic             in_acc;
  logic             out_free;
  logic             scan_hit;
  logic             scan_last;
  logic [IDX_W-1:0] prev_idx;
  logic [CNT_W-1:0] prev_count;
  logic [CNT_W-1:0] cnt_sat;
  logic             shift_ok;
  logic             shift_more;

  assign in_i.ready = (state_q == sost_pkg::ST_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;
  assign out_free   = !out_valid_q || out_o.ready;

  // read data in SCAN belongs to cmp_idx_q, in SHIFT to the slot before dst_q
  assign scan_hit   = written_q[cmp_idx_q] && (mem_rdata_i.key == key_q);
  assign scan_last  = ({1'b0, cmp_idx_q} + LEN_W'(1)) == len_q;
  assign prev_idx   = IDX_W'(dst_q - IDX_W'(1));
  assign prev_count = written_q[prev_idx] ? mem_rdata_i.count : '0;
  assign cnt_sat    = (mem_rdata_i.count == '1) ? mem_rdata_i.count
                                                : CNT_W'(mem_rdata_i.count + CNT_W'(1));
  assign shift_ok   = (cfg_i.mode == sost_pkg::POL_FREQ) ? (prev_count < e_count_q) : 1'b1;
  assign shift_more = (cfg_i.mode != sost_pkg::POL_TRANSPOSE) && (prev_idx != '0);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      sost_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (in_i.op == sost_pkg::OP_WRITE || cfg_i.len == '0) begin
            state_d = sost_pkg::ST_DONE;
          end else begin
            state_d = sost_pkg::ST_SCAN;
          end
        end
      end
      sost_pkg::ST_SCAN: begin
        if (scan_hit) begin
          case (cfg_i.mode)
            sost_pkg::POL_PLAIN: state_d = sost_pkg::ST_DONE;
            sost_pkg::POL_FREQ: begin
              state_d = (cmp_idx_q == '0) ? sost_pkg::ST_PLACE : sost_pkg::ST_SHIFT;
            end
            default: begin
              state_d = (cmp_idx_q == '0) ? sost_pkg::ST_DONE : sost_pkg::ST_SHIFT;
            end
          endcase
        end else if (scan_last) begin
          state_d = sost_pkg::ST_DONE;
        end
      end
      sost_pkg::ST_SHIFT: begin
        if (!(shift_ok && shift_more)) begin
          state_d = sost_pkg::ST_PLACE;
        end
      end
      sost_pkg::ST_PLACE: state_d = sost_pkg::ST_DONE;
      sost_pkg::ST_DONE: begin
        if (out_free) begin
          state_d = sost_pkg::ST_IDLE;
        end
      end
      default: state_d = sost_pkg::ST_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    cmp_idx_d   = cmp_idx_q;
    pos_d       = pos_q;
    dst_d       = dst_q;
    len_d       = len_q;
    key_d       = key_q;
    e_count_d   = e_count_q;
    found_d     = found_q;
    written_d   = written_q;
    out_found_d = out_found_q;
    out_key_d   = out_key_q;
    out_old_d   = out_old_q;
    out_new_d   = out_new_q;
    out_cnt_d   = out_cnt_q;
    out_valid_d = out_valid_q && !out_o.ready;
    mem_o.we    = 1'b0;
    mem_o.waddr = dst_q;
    mem_o.wdata = mem_rdata_i;
    mem_o.raddr = '0;

    case (state_q)
      sost_pkg::ST_IDLE: begin
        // slot 0 is read every idle cycle, ready for the first compare
        if (in_acc) begin
          key_d     = in_i.key;
          len_d     = cfg_i.len;
          cmp_idx_d = '0;
          pos_d     = '0;
          dst_d     = '0;
          e_count_d = '0;
          found_d   = 1'b0;
          if (in_i.op == sost_pkg::OP_WRITE &&
              32'(in_i.slot_index) < 32'(sost_pkg::TABLE_DEPTH)) begin
            mem_o.we                          = 1'b1;
            mem_o.waddr                       = IDX_W'(in_i.slot_index);
            mem_o.wdata.key                   = in_i.key;
            mem_o.wdata.count                 = '0;
            written_d[IDX_W'(in_i.slot_index)] = 1'b1;
          end
        end
      end
      sost_pkg::ST_SCAN: begin
        if (scan_hit) begin
          found_d     = 1'b1;
          pos_d       = cmp_idx_q;
          dst_d       = cmp_idx_q;
          e_count_d   = (cfg_i.mode == sost_pkg::POL_FREQ) ? cnt_sat : mem_rdata_i.count;
          mem_o.raddr = IDX_W'(cmp_idx_q - IDX_W'(1));
        end else begin
          cmp_idx_d   = IDX_W'(cmp_idx_q + IDX_W'(1));
          mem_o.raddr = IDX_W'(cmp_idx_q + IDX_W'(1));
        end
      end
      sost_pkg::ST_SHIFT: begin
        // move the neighbour back one slot; fetch the next one meanwhile
        if (shift_ok) begin
          mem_o.we         = 1'b1;
          mem_o.waddr      = dst_q;
          mem_o.wdata      = mem_rdata_i;
          written_d[dst_q] = written_q[prev_idx];
          dst_d            = prev_idx;
        end
        mem_o.raddr = IDX_W'(prev_idx - IDX_W'(1));
      end
      sost_pkg::ST_PLACE: begin
        mem_o.we          = 1'b1;
        mem_o.waddr       = dst_q;
        mem_o.wdata.key   = key_q;
        mem_o.wdata.count = e_count_q;
        written_d[dst_q]  = 1'b1;
      end
      sost_pkg::ST_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_found_d = found_q;
          out_key_d   = found_q ? key_q : '0;
          out_old_d   = sost_pkg::POS_W'(pos_q);
          out_new_d   = sost_pkg::POS_W'(dst_q);
          out_cnt_d   = sost_pkg::HIT_W'(e_count_q);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sost_pkg::ST_IDLE;
      written_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      written_q   <= written_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmp_idx_q   <= cmp_idx_d;
    pos_q       <= pos_d;
    dst_q       <= dst_d;
    len_q       <= len_d;
    key_q       <= key_d;
    e_count_q   <= e_count_d;
    found_q     <= found_d;
    out_found_q <= out_found_d;
    out_key_q   <= out_key_d;
    out_old_q   <= out_old_d;
    out_new_q   <= out_new_d;
    out_cnt_q   <= out_cnt_d;
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.found        = out_found_q;
  assign out_o.match_key    = out_key_q;
  assign out_o.old_position = out_old_q;
  assign out_o.new_position = out_new_q;
  assign out_o.hit_count    = out_cnt_q;

endmodule

// File: rtl/core/self_organizing_search_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// self_organizing_search_table
// Key table with hit counts, searched front to back, reorganised after a hit
// unless the policy is plain.
// Input channel in_i carries one beat per item: op selects a write (load key
// into slot_index, clear its count) or a search for key. Every item gives
// exactly one result beat on out_o: found, the key, its slot before and after
// reordering and its hit count; misses and writes give all zeros.
// Registers on the cfg port: policy_mode (plain, move to front, transpose,
// frequency count) and table_length; write them only while the block is idle.
// A write goes straight to the result register. A search scans slots front to
// back up to the hit (at most table_length), then moves entries back one at a
// time, spends a shift step without a move where a frequency reorder stops
// short, writes a moved or recounted entry back and loads the result. The entry
// RAM has one read and one write port; the scan and the reorder walk each stream
// one slot per cycle through it.
// One item is in work at a time; a new item is taken while a result waits.
// Reset clears the written flags and loads policy 0 and length 64.
// When out_o stalls the result is held and the next finished item waits.
// ----------------------------------------------------------------------------
module self_organizing_search_table (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [sost_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [sost_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  sost_in_if.sink                          in_i,
  sost_out_if.source                       out_o
);

  sost_pkg::policy_e              mode_q;
  logic [sost_pkg::TLEN_W-1:0]    tlen_q;
  sost_pkg::cfg_t                 cfg;
  sost_pkg::mem_req_t             mem_req;
  sost_pkg::entry_t               mem_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= sost_pkg::POL_PLAIN;
      tlen_q <= sost_pkg::TLEN_RESET;
    end else if (cfg_we_i) begin
      case (sost_pkg::reg_idx_e'(cfg_index_i))
        sost_pkg::REG_POLICY_MODE: begin
          mode_q <= sost_pkg::policy_e'(cfg_data_i[sost_pkg::MODE_W-1:0]);
        end
        sost_pkg::REG_TABLE_LENGTH: tlen_q <= cfg_data_i[sost_pkg::TLEN_W-1:0];
        default: ;
      endcase
    end
  end

  // lengths beyond the depth search the whole table
  always_comb begin
    cfg.mode = mode_q;
    if (32'(tlen_q) > 32'(sost_pkg::TABLE_DEPTH)) begin
      cfg.len = sost_pkg::LEN_W'(sost_pkg::TABLE_DEPTH);
    end else begin
      cfg.len = sost_pkg::LEN_W'(tlen_q);
    end
  end

  sost_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_i        (in_i),
    .out_o       (out_o),
    .mem_o       (mem_req),
    .mem_rdata_i (mem_rdata)
  );

  sost_ram #(
    .DEPTH (sost_pkg::TABLE_DEPTH),
    .WIDTH ($bits(sost_pkg::entry_t))
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_req.we),
    .waddr_i (mem_req.waddr),
    .wdata_i (mem_req.wdata),
    .raddr_i (mem_req.raddr),
    .rdata_o (mem_rdata)
  );

endmodule

// File: rtl/core/sost_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sost_checker
// Port-level checks of the search table, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sost_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_ready_i,
  input logic                       out_valid_i,
  input logic                       out_ready_i,
  input logic                       found_i,
  input logic [sost_pkg::KEY_W-1:0] match_key_i,
  input logic [sost_pkg::POS_W-1:0] old_pos_i,
  input logic [sost_pkg::POS_W-1:0] new_pos_i,
  input logic [sost_pkg::HIT_W-1:0] hit_count_i
);

  // items taken whose result beat has not yet gone out
  logic [1:0] pend_q, pend_d;
  logic       in_beat, out_beat;

  assign in_beat  = in_valid_i && in_ready_i;
  assign out_beat = out_valid_i && out_ready_i;

  always_comb begin
    pend_d = pend_q;
    if (in_beat && !out_beat) begin
      pend_d = 2'(pend_q + 2'd1);
    end else if (out_beat && !in_beat) begin
      pend_d = 2'(pend_q - 2'd1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_d;
    end
  end

  `SOST_NEVER(a_no_orphan_result, out_valid_i && pend_q == 2'd0, "result without item")
  `SOST_NEVER(a_full_not_ready, pend_q == 2'd2 && in_ready_i, "item taken while full")
  `SOST_ASSERT(a_miss_zero, out_valid_i && !found_i |-> match_key_i == '0 && old_pos_i == '0 && new_pos_i == '0 && hit_count_i == '0, "miss result not zero")
  `SOST_ASSERT(a_moves_forward, out_valid_i && found_i |-> new_pos_i <= old_pos_i, "hit moved backwards")
  `SOST_ASSERT(a_out_hold, out_valid_i && !out_ready_i |=> out_valid_i && $stable(match_key_i) && $stable(new_pos_i) && $stable(hit_count_i), "stalled result changed")

endmodule

bind self_organizing_search_table sost_checker u_sost_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .found_i     (out_o.found),
  .match_key_i (out_o.match_key),
  .old_pos_i   (out_o.old_position),
  .new_pos_i   (out_o.new_position),
  .hit_count_i (out_o.hit_count)
);
